/* design/assert_macros.svh */
// Assertion macros shared by the cache table RTL.
// Depends on nothing; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/lfu_pkg.sv */
// Types and codes for the LFU cache table.
// Depends on nothing; used by lfu_cell and lfu_cache_table.
package lfu_pkg;

    localparam logic [1:0] OP_PUT    = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [6:0] CAP_RESET = 7'd64;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] lookup_key;
        logic [63:0] store_value;
    } req_t;

    typedef struct packed {
        logic        success;
        logic [63:0] found_value;
        logic        released_valid;
        logic [63:0] released_value;
        logic [6:0]  occupancy;
    } rsp_t;

    // Running search result handed from cell to cell
    typedef struct packed {
        logic        match_found;
        logic [63:0] match_value;
        logic        free_found;
        logic        vict_found;
        logic [31:0] vict_count;
        logic [63:0] vict_stamp;
        logic [63:0] vict_value;
    } carry_t;

    // Update broadcast to all cells
    typedef struct packed {
        logic        clear_all;
        logic        write;
        logic        bump;
        logic        kill;
        logic [63:0] value;
        logic [63:0] stamp;
    } cmd_t;

endpackage

/* design/lfu_cell.sv */
// One entry of the LFU cache table plus its stage of the search chain.
// Depends on lfu_pkg.
module lfu_cell #(
    parameter int IDX_W    = 6,
    parameter int KEY_BITS = 64,
    parameter int MY_IDX   = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [KEY_BITS-1:0]  scan_key,
    input  lfu_pkg::carry_t      cin,
    input  logic [IDX_W-1:0]     cin_match_idx,
    input  logic [IDX_W-1:0]     cin_free_idx,
    input  logic [IDX_W-1:0]     cin_vict_idx,
    output lfu_pkg::carry_t      cout,
    output logic [IDX_W-1:0]     cout_match_idx,
    output logic [IDX_W-1:0]     cout_free_idx,
    output logic [IDX_W-1:0]     cout_vict_idx,
    input  lfu_pkg::cmd_t        cmd,
    input  logic [IDX_W-1:0]     cmd_idx
);
    import lfu_pkg::*;

    localparam logic [IDX_W-1:0] SELF = IDX_W'(MY_IDX);

    logic                valid_reg, valid_next;
    logic [KEY_BITS-1:0] key_reg;
    logic [63:0]         value_reg;
    logic [31:0]         count_reg;
    logic [63:0]         stamp_reg;

    carry_t              carry_reg, carry_next;
    logic [IDX_W-1:0]    midx_reg, midx_next;
    logic [IDX_W-1:0]    fidx_reg, fidx_next;
    logic [IDX_W-1:0]    vidx_reg, vidx_next;

    logic hit, better, sel;

    // Fold this entry into the running search result
    always_comb
    begin
        hit    = valid_reg && (key_reg == scan_key);
        better = valid_reg && (!cin.vict_found || (count_reg < cin.vict_count) ||
                 ((count_reg == cin.vict_count) && (stamp_reg < cin.vict_stamp)));
        carry_next = cin;
        midx_next  = cin_match_idx;
        fidx_next  = cin_free_idx;
        vidx_next  = cin_vict_idx;
        if (hit && !cin.match_found)
        begin
            carry_next.match_found = 1'b1;
            carry_next.match_value = value_reg;
            midx_next              = SELF;
        end
        if (!valid_reg && !cin.free_found)
        begin
            carry_next.free_found = 1'b1;
            fidx_next             = SELF;
        end
        if (better)
        begin
            carry_next.vict_found = 1'b1;
            carry_next.vict_count = count_reg;
            carry_next.vict_stamp = stamp_reg;
            carry_next.vict_value = value_reg;
            vidx_next             = SELF;
        end
    end

    // Advance the chain one cell per cycle
    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        midx_reg  <= midx_next;
        fidx_reg  <= fidx_next;
        vidx_reg  <= vidx_next;
    end

    assign cout           = carry_reg;
    assign cout_match_idx = midx_reg;
    assign cout_free_idx  = fidx_reg;
    assign cout_vict_idx  = vidx_reg;

    // Entry valid bit
    assign sel = (cmd_idx == SELF);
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.clear_all)
            valid_next = 1'b0;
        else if (sel && cmd.write)
            valid_next = 1'b1;
        else if (sel && cmd.kill)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        if (sel && cmd.write)
        begin
            key_reg   <= scan_key;
            value_reg <= cmd.value;
            count_reg <= 32'd1;
            stamp_reg <= cmd.stamp;
        end
        else if (sel && cmd.bump)
        begin
            if (count_reg != COUNT_MAX)
                count_reg <= count_reg + 32'd1;
            stamp_reg <= cmd.stamp;
        end
    end

endmodule

/* design/lfu_cache_table.sv */
// Top level of the LFU cache table: sequencer, search chain and result register.
// Depends on lfu_pkg, lfu_cell and assert_macros.svh.
//
//  channel | direction | handshake            | word
//  req     | in        | req_valid/req_stall  | req_t: operation, key, value
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_t: result of one operation
//  cfg     | in        | cfg_valid/cfg_ready  | capacity, 7 bits
//
// A request is latched in ST_IDLE, its search wave then crosses the chain of cells
// in ST_SCAN (one cell per cycle), and ST_APPLY updates the table.
// rst_n clears all valid bits, the stamp counter and the occupancy; capacity
// returns to 64. A stalled result holds in the output register while the next
// word is accepted; the update cycle waits only when that register is still full.
`include "assert_macros.svh"
module lfu_cache_table #(
    parameter int ENTRIES  = 64,
    parameter int KEY_BITS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  lfu_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output lfu_pkg::rsp_t rsp,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [6:0]    cfg_data
);
    import lfu_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CW    = (CNT_W > 7) ? CNT_W : 7;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    scan_cnt_reg;
    logic [1:0]          op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [63:0]         val_reg;
    logic [6:0]          cap_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [63:0]         stamp_reg;
    logic                stamp_inc;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg, rsp_next;
    logic                accept, fire;

    carry_t              chain     [ENTRIES+1];
    logic [IDX_W-1:0]    chain_mi  [ENTRIES+1];
    logic [IDX_W-1:0]    chain_fi  [ENTRIES+1];
    logic [IDX_W-1:0]    chain_vi  [ENTRIES+1];
    cmd_t                cmd;
    logic [IDX_W-1:0]    cmd_idx;

    logic [CW-1:0]       cap_x, ent_x, cap_eff, count_x;
    carry_t              res;

    assign accept    = req_valid && !req_stall;
    assign cfg_ready = 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (req_valid) state_next = ST_SCAN;
            ST_SCAN:  if (scan_cnt_reg == IDX_W'(ENTRIES - 1)) state_next = ST_APPLY;
            ST_APPLY: if (fire) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        req_stall = 1'b1;
        fire      = 1'b0;
        case (state_reg)
            ST_IDLE:  req_stall = 1'b0;
            ST_SCAN:  req_stall = 1'b1;
            ST_APPLY: fire = !rsp_valid_reg || !rsp_stall;
            default:  req_stall = 1'b1;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            stamp_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                scan_cnt_reg <= '0;
            else if (state_reg == ST_SCAN)
                scan_cnt_reg <= scan_cnt_reg + IDX_W'(1);
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
            if (fire)
            begin
                count_reg <= count_next;
                if (stamp_inc)
                    stamp_reg <= stamp_reg + 64'd1;
            end
            if (fire)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Hold the request and the result word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req.operation;
            key_reg <= req.lookup_key[KEY_BITS-1:0];
            val_reg <= req.store_value;
        end
        if (fire)
            rsp_reg <= rsp_next;
    end

    // Seed the search wave at the head of the chain
    assign chain[0]    = '0;
    assign chain_mi[0] = '0;
    assign chain_fi[0] = '0;
    assign chain_vi[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        lfu_cell #(
            .IDX_W    (IDX_W),
            .KEY_BITS (KEY_BITS),
            .MY_IDX   (g)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .scan_key       (key_reg),
            .cin            (chain[g]),
            .cin_match_idx  (chain_mi[g]),
            .cin_free_idx   (chain_fi[g]),
            .cin_vict_idx   (chain_vi[g]),
            .cout           (chain[g+1]),
            .cout_match_idx (chain_mi[g+1]),
            .cout_free_idx  (chain_fi[g+1]),
            .cout_vict_idx  (chain_vi[g+1]),
            .cmd            (cmd),
            .cmd_idx        (cmd_idx)
        );
    end

    // Decide the update from the search result at the tail of the chain
    always_comb
    begin
        res       = chain[ENTRIES];
        cap_x     = CW'(cap_reg);
        ent_x     = CW'(ENTRIES);
        cap_eff   = (cap_x > ent_x) ? ent_x : cap_x;
        count_x   = CW'(count_reg);
        cmd       = '0;
        cmd.value = val_reg;
        cmd.stamp = stamp_reg;
        cmd_idx   = chain_mi[ENTRIES];
        count_next = count_reg;
        stamp_inc  = 1'b0;
        rsp_next   = '0;
        if (op_reg == OP_CLEAR)
        begin
            cmd.clear_all    = 1'b1;
            count_next       = '0;
            rsp_next.success = 1'b1;
        end
        else if (cap_eff != '0)
        begin
            case (op_reg)
                OP_PUT:
                begin
                    if (res.match_found)
                    begin
                        cmd.write               = 1'b1;
                        rsp_next.released_valid = 1'b1;
                        rsp_next.released_value = res.match_value;
                    end
                    else if ((count_x >= cap_eff) && res.vict_found)
                    begin
                        cmd.write               = 1'b1;
                        cmd_idx                 = chain_vi[ENTRIES];
                        rsp_next.released_valid = 1'b1;
                        rsp_next.released_value = res.vict_value;
                    end
                    else if (res.free_found)
                    begin
                        cmd.write  = 1'b1;
                        cmd_idx    = chain_fi[ENTRIES];
                        count_next = count_reg + CNT_W'(1);
                    end
                    rsp_next.success = cmd.write;
                    stamp_inc        = cmd.write;
                end
                OP_GET:
                begin
                    if (res.match_found)
                    begin
                        cmd.bump             = 1'b1;
                        stamp_inc            = 1'b1;
                        rsp_next.success     = 1'b1;
                        rsp_next.found_value = res.match_value;
                    end
                end
                default:
                begin
                    if (res.match_found)
                    begin
                        cmd.kill             = 1'b1;
                        rsp_next.success     = 1'b1;
                        rsp_next.found_value = res.match_value;
                        if (count_reg != '0)
                            count_next = count_reg - CNT_W'(1);
                    end
                end
            endcase
        end
        rsp_next.occupancy = 7'(count_next);
        if (!fire)
        begin
            cmd.clear_all = 1'b0;
            cmd.write     = 1'b0;
            cmd.bump      = 1'b0;
            cmd.kill      = 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_IMPL(a_occ_bound, 1'b1, count_reg <= CNT_W'(ENTRIES))
    `ASSERT_IMPL(a_busy_stalls, state_reg != ST_IDLE, req_stall)
    `ASSERT_NEXT(a_fire_shows, fire, rsp_valid_reg && state_reg == ST_IDLE)

endmodule

/* bench/lfu_cache_table_tb.sv */
// Self-checking bench for lfu_cache_table: a directed table of requests, then random traffic.
// Each response is checked against a behavioral LFU table model kept inside this module.
// Depends on lfu_pkg and the lfu_cache_table RTL.
`timescale 1ns / 1ps
module lfu_cache_table_tb;
    import lfu_pkg::*;

    localparam int ENTRIES = 64;
    localparam int OP_LATENCY = ENTRIES + 2;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    req_t       req;
    logic       rsp_valid;
    logic       rsp_stall;
    rsp_t       rsp;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [6:0] cfg_data;

    lfu_cache_table dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Table model state
    bit          tbl_valid [ENTRIES];
    bit [63:0]   tbl_key [ENTRIES];
    bit [63:0]   tbl_value [ENTRIES];
    bit [31:0]   tbl_count [ENTRIES];
    bit [63:0]   tbl_stamp [ENTRIES];
    bit [63:0]   stamp_next;
    int          held;
    bit [6:0]    cap_reg;

    rsp_t        pending_rsp [$];
    int          mismatches;
    int          rsp_seen;
    bit          idle_rsp_side;
    int          rsp_wait;

    // Key pool keeps hit rate high
    bit [63:0]   key_pool [16];

    // Directed row: request plus optional typed expectation
    typedef struct {
        req_t       word;
        bit         has_exp;
        rsp_t       exp;
    } row_t;

    initial begin
        clk = 1'b0;
    end
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50ms;
        $display("status: fail");
        $finish;
    end

    function automatic rsp_t lfu_apply(req_t w);
        rsp_t r;
        int   cap;
        int   slot;
        int   best;
        r = '0;
        cap = (cap_reg > ENTRIES) ? ENTRIES : cap_reg;
        slot = -1;
        if (w.operation == OP_CLEAR) begin
            foreach (tbl_valid[i]) tbl_valid[i] = 0;
            held = 0;
            r.success = 1'b1;
        end else if (cap != 0) begin
            foreach (tbl_valid[i])
                if (slot < 0 && tbl_valid[i] && tbl_key[i] == w.lookup_key) slot = i;
            if (w.operation == OP_PUT) begin
                if (slot >= 0) begin
                    r.released_valid = 1'b1;
                    r.released_value = tbl_value[slot];
                end else begin
                    if (held >= cap) begin
                        best = -1;
                        foreach (tbl_valid[i])
                            if (tbl_valid[i] && (best < 0 || tbl_count[i] < tbl_count[best] ||
                                (tbl_count[i] == tbl_count[best] &&
                                 tbl_stamp[i] < tbl_stamp[best])))
                                best = i;
                        slot = best;
                        if (slot >= 0) begin
                            r.released_valid = 1'b1;
                            r.released_value = tbl_value[slot];
                            tbl_valid[slot] = 0;
                            held--;
                        end
                    end
                    if (slot < 0)
                        foreach (tbl_valid[i])
                            if (slot < 0 && !tbl_valid[i]) slot = i;
                    if (slot >= 0) held++;
                end
                if (slot >= 0) begin
                    tbl_valid[slot] = 1;
                    tbl_key[slot] = w.lookup_key;
                    tbl_value[slot] = w.store_value;
                    tbl_count[slot] = 1;
                    tbl_stamp[slot] = stamp_next++;
                    r.success = 1'b1;
                end
            end else if (w.operation == OP_GET) begin
                if (slot >= 0) begin
                    r.success = 1'b1;
                    r.found_value = tbl_value[slot];
                    if (tbl_count[slot] != COUNT_MAX) tbl_count[slot]++;
                    tbl_stamp[slot] = stamp_next++;
                end
            end else if (slot >= 0) begin
                r.success = 1'b1;
                r.found_value = tbl_value[slot];
                tbl_valid[slot] = 0;
                if (held > 0) held--;
            end
        end
        r.occupancy = held[6:0];
        return r;
    endfunction

    // Hand one word to the block and queue its expected response
    task automatic send_word(req_t w, bit has_exp, rsp_t exp_rsp);
        rsp_t predicted;
        repeat ($urandom_range(0, 11) * $urandom_range(0, 1)) @(posedge clk);
        req_valid <= 1'b1;
        req <= w;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        req_valid <= 1'b0;
        predicted = lfu_apply(w);
        if (has_exp && predicted !== exp_rsp)
            $display("directed row disagrees with predictor: %h vs %h", exp_rsp, predicted);
        pending_rsp.push_back(has_exp ? exp_rsp : predicted);
        // Drop valid before the next word
        @(posedge clk);
    endtask

    // Write capacity while the block is idle
    task automatic write_capacity(bit [6:0] c);
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (OP_LATENCY + 4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= c;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cap_reg = c;
    endtask

    function automatic req_t make_word(bit [1:0] op, bit [63:0] k, bit [63:0] v);
        req_t w;
        w.operation = op;
        w.lookup_key = k;
        w.store_value = v;
        return w;
    endfunction

    function automatic rsp_t make_rsp(bit s, bit [63:0] f, bit rv, bit [63:0] rval,
                                      bit [6:0] occ);
        rsp_t r;
        r.success = s;
        r.found_value = f;
        r.released_valid = rv;
        r.released_value = rval;
        r.occupancy = occ;
        return r;
    endfunction

    function automatic req_t random_word();
        bit [1:0]  op;
        bit [63:0] k;
        int        pick;
        pick = $urandom_range(0, 99);
        op = (pick < 45) ? OP_PUT : (pick < 80) ? OP_GET : (pick < 98) ? OP_REMOVE : OP_CLEAR;
        k = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                        : key_pool[$urandom_range(0, 15)];
        return make_word(op, k, {$urandom, $urandom});
    endfunction

    // Response side: hold each word for a drawn number of cycles, compare against
    // oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rsp_stall <= 1'b1;
            rsp_wait = 0;
        end else begin
            if (rsp_valid && !rsp_stall) begin
                rsp_seen++;
                if (pending_rsp.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected response %h", rsp);
                end else begin
                    rsp_t e;
                    e = pending_rsp.pop_front();
                    if (rsp.success !== e.success || rsp.found_value !== e.found_value ||
                        rsp.released_valid !== e.released_valid ||
                        rsp.released_value !== e.released_value ||
                        rsp.occupancy !== e.occupancy) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp s%b f%h rv%b r%h o%0d act s%b f%h rv%b r%h o%0d",
                                     e.success, e.found_value, e.released_valid,
                                     e.released_value, e.occupancy, rsp.success,
                                     rsp.found_value, rsp.released_valid,
                                     rsp.released_value, rsp.occupancy);
                    end
                end
                rsp_wait = idle_rsp_side ? 0 : $urandom_range(0, 11);
            end else if (rsp_valid && rsp_wait > 0) begin
                rsp_wait--;
            end
            rsp_stall <= (rsp_wait != 0);
        end
    end

    initial
    begin
        row_t       rows [$];
        bit [6:0]   caps [6];
        int         sent;
        rsp_t       zero_rsp;
        zero_rsp = '0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        rsp_stall = 1'b1;
        idle_rsp_side = 1'b0;
        mismatches = 0;
        rsp_seen = 0;
        stamp_next = 0;
        held = 0;
        cap_reg = CAP_RESET;
        foreach (tbl_valid[i]) tbl_valid[i] = 0;
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: reset state, extremes, every operation
        rows.push_back('{make_word(OP_GET, 64'd0, 64'd0), 1, zero_rsp});
        rows.push_back('{make_word(OP_REMOVE, '1, '1), 1, zero_rsp});
        rows.push_back('{make_word(OP_PUT, 64'd0, '1), 1, make_rsp(1, 0, 0, 0, 7'd1)});
        rows.push_back('{make_word(OP_PUT, '1, 64'd0), 1, make_rsp(1, 0, 0, 0, 7'd2)});
        rows.push_back('{make_word(OP_GET, 64'd0, 64'd5), 1, make_rsp(1, '1, 0, 0, 7'd2)});
        rows.push_back('{make_word(OP_PUT, 64'd0, 64'h5A5A), 1, make_rsp(1, 0, 1, '1, 7'd2)});
        rows.push_back('{make_word(OP_REMOVE, '1, 64'd3), 1, make_rsp(1, 0, 0, 0, 7'd1)});
        rows.push_back('{make_word(OP_GET, 64'h1234, 64'd0), 1, make_rsp(0, 0, 0, 0, 7'd1)});
        rows.push_back('{make_word(OP_CLEAR, 64'd7, 64'd7), 1, make_rsp(1, 0, 0, 0, 7'd0)});
        rows.push_back('{make_word(OP_PUT, 64'hAAAA_5555_AAAA_5555, 64'h5555_AAAA_5555_AAAA),
                         0, zero_rsp});
        rows.push_back('{make_word(OP_GET, 64'hAAAA_5555_AAAA_5555, 64'd0), 0, zero_rsp});
        foreach (rows[i]) send_word(rows[i].word, rows[i].has_exp, rows[i].exp);

        // Capacity 2: eviction by count, then by age
        write_capacity(7'd2);
        send_word(make_word(OP_PUT, 64'd10, 64'd100), 0, zero_rsp);
        send_word(make_word(OP_PUT, 64'd11, 64'd101), 0, zero_rsp);
        send_word(make_word(OP_GET, 64'd11, 64'd0), 0, zero_rsp);
        send_word(make_word(OP_PUT, 64'd12, 64'd102), 0, zero_rsp);
        send_word(make_word(OP_PUT, 64'd13, 64'd103), 0, zero_rsp);

        // Capacity zero disables all but clear
        write_capacity(7'd0);
        send_word(make_word(OP_PUT, 64'd1, 64'd1), 1, make_rsp(0, 0, 0, 0, 7'(held)));
        send_word(make_word(OP_GET, 64'd11, 64'd1), 1, make_rsp(0, 0, 0, 0, 7'(held)));
        send_word(make_word(OP_CLEAR, 64'd0, 64'd0), 1, make_rsp(1, 0, 0, 0, 7'd0));

        // Random phases across capacities, extremes included
        caps[0] = 7'd127; caps[1] = 7'd1; caps[2] = 7'd4;
        caps[3] = 7'd64; caps[4] = 7'd65; caps[5] = 7'd3;
        foreach (caps[p]) begin
            write_capacity(caps[p]);
            idle_rsp_side = (p == 3);
            for (sent = 0; sent < 170; sent++) begin
                if (sent == 85) while (pending_rsp.size() != 0) @(posedge clk);
                send_word(random_word(), 0, zero_rsp);
            end
        end
        // Lower capacity below occupancy without dropping entries
        write_capacity(7'd2);
        for (sent = 0; sent < 40; sent++) send_word(random_word(), 0, zero_rsp);

        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (OP_LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

/* lfu_cache_table.f */
+incdir+design
design/lfu_pkg.sv
design/lfu_cell.sv
design/lfu_cache_table.sv
bench/lfu_cache_table_tb.sv
